### sv/pll_divider_search_core_macros.svh
// Assertion macros shared by the PLL divider search RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef PLL_DIVIDER_SEARCH_CORE_MACROS_SVH
`define PLL_DIVIDER_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pll_divider_search_core: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pll_divider_search_core: assertion failed");

`endif

### sv/pds_pkg.sv
// Package for the PLL divider search: field widths, defaults and the
// types shared by the controller, the datapath and the top level.
package pds_pkg;

    localparam int REF_W      = 27;
    localparam int TGT_W      = 32;
    localparam int M_OUT_W    = 9;
    localparam int N_OUT_W    = 5;
    localparam int CODE_W     = 2;

    localparam logic [REF_W-1:0] REF_RESET = REF_W'(12000000);

    localparam int DEF_FEEDBACK_STEPS = 512;
    localparam int DEF_INPUT_STEPS    = 32;
    localparam int DEF_OUTPUT_STEPS   = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_DONE
    } pds_state_t;

    typedef enum logic [1:0] {
        RES_REF,
        RES_HIT,
        RES_MISS
    } pds_res_t;

    typedef struct packed {
        logic     load;
        logic     next_m;
        logic     next_n;
        logic     next_d;
        logic     finish;
        pds_res_t res_kind;
    } pds_cmd_t;

    typedef struct packed {
        logic ref_eq;
        logic hit;
        logic m_last;
        logic n_last;
        logic d_last;
    } pds_status_t;

endpackage

### sv/pds_datapath.sv
// Datapath of the PLL divider search: reference register, candidate
// counters, running products, match compare and result registers. Uses pds_pkg.
module pds_datapath #(
    parameter int FEEDBACK_STEPS = pds_pkg::DEF_FEEDBACK_STEPS,
    parameter int INPUT_STEPS    = pds_pkg::DEF_INPUT_STEPS,
    parameter int OUTPUT_STEPS   = pds_pkg::DEF_OUTPUT_STEPS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pds_pkg::REF_W-1:0]     cfg_data,
    input  logic [pds_pkg::TGT_W-1:0]     target_freq,
    input  pds_pkg::pds_cmd_t             cmd,
    output pds_pkg::pds_status_t          status,
    output logic                          found,
    output logic [pds_pkg::M_OUT_W-1:0]   feedback_setting,
    output logic [pds_pkg::N_OUT_W-1:0]   input_setting,
    output logic [pds_pkg::CODE_W-1:0]    output_div_code
);
    import pds_pkg::*;

    localparam int M_W     = $clog2(FEEDBACK_STEPS);
    localparam int N_W     = $clog2(INPUT_STEPS);
    localparam int D_W     = (OUTPUT_STEPS > 1) ? $clog2(OUTPUT_STEPS) : 1;
    localparam int PROD_W  = REF_W + $clog2(FEEDBACK_STEPS + 2);
    localparam int Q_W     = $clog2(INPUT_STEPS + 2);
    localparam int BASE_W  = TGT_W + 1 + Q_W;
    localparam int BND_W   = BASE_W + OUTPUT_STEPS - 1;
    localparam int CMP_W   = (BND_W > PROD_W) ? BND_W : PROD_W;

    logic [REF_W-1:0]   ref_reg;
    logic [TGT_W-1:0]   target_reg,  target_next;
    logic [PROD_W-1:0]  prod_reg,    prod_next;
    logic [BASE_W-1:0]  lo_base_reg, lo_base_next;
    logic [BASE_W-1:0]  hi_base_reg, hi_base_next;
    logic [M_W-1:0]     m_reg,       m_next;
    logic [N_W-1:0]     n_reg,       n_next;
    logic [D_W-1:0]     d_reg,       d_next;

    logic               found_reg,   found_next;
    logic [M_OUT_W-1:0] fb_reg,      fb_next;
    logic [N_OUT_W-1:0] in_reg,      in_next;
    logic [CODE_W-1:0]  code_reg,    code_next;

    logic [TGT_W:0]     target_inc;
    logic [CMP_W-1:0]   lo_bound;
    logic [CMP_W-1:0]   hi_bound;
    logic [CMP_W-1:0]   prod_ext;
    logic [CODE_W-1:0]  d_ext;

    // The reference register is only written while the search is idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= REF_RESET;
        end
        else if (cfg_we)
        begin
            ref_reg <= cfg_data;
        end
    end

    assign target_inc = {1'b0, target_reg} + (TGT_W + 1)'(1);

    // A candidate floor(P / q) >> d equals T exactly when
    // q * (T << d) <= P < q * ((T + 1) << d), so no divider is needed.
    assign prod_ext = CMP_W'(prod_reg);
    assign lo_bound = CMP_W'(lo_base_reg) << d_reg;
    assign hi_bound = CMP_W'(hi_base_reg) << d_reg;

    assign status.hit    = (prod_ext >= lo_bound) && (prod_ext < hi_bound);
    assign status.ref_eq = (target_reg == TGT_W'(ref_reg));
    assign status.m_last = (m_reg == M_W'(FEEDBACK_STEPS - 1));
    assign status.n_last = (n_reg == N_W'(INPUT_STEPS - 1));
    assign status.d_last = (d_reg == D_W'(OUTPUT_STEPS - 1));

    always_comb
    begin
        target_next  = target_reg;
        prod_next    = prod_reg;
        lo_base_next = lo_base_reg;
        hi_base_next = hi_base_reg;
        m_next       = m_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        if (cmd.load)
        begin
            target_next  = target_freq;
            prod_next    = PROD_W'({ref_reg, 1'b0});
            lo_base_next = BASE_W'({target_freq, 1'b0});
            hi_base_next = BASE_W'({({1'b0, target_freq} + (TGT_W + 1)'(1)), 1'b0});
            m_next       = '0;
            n_next       = '0;
            d_next       = '0;
        end
        else if (cmd.next_m)
        begin
            prod_next = prod_reg + PROD_W'(ref_reg);
            m_next    = m_reg + M_W'(1);
        end
        else if (cmd.next_n)
        begin
            prod_next    = PROD_W'({ref_reg, 1'b0});
            lo_base_next = lo_base_reg + BASE_W'(target_reg);
            hi_base_next = hi_base_reg + BASE_W'(target_inc);
            m_next       = '0;
            n_next       = n_reg + N_W'(1);
        end
        else if (cmd.next_d)
        begin
            prod_next    = PROD_W'({ref_reg, 1'b0});
            lo_base_next = BASE_W'({target_reg, 1'b0});
            hi_base_next = BASE_W'({target_inc, 1'b0});
            m_next       = '0;
            n_next       = '0;
            d_next       = d_reg + D_W'(1);
        end
    end

    assign d_ext = CODE_W'(d_reg);

    always_comb
    begin
        found_next = found_reg;
        fb_next    = fb_reg;
        in_next    = in_reg;
        code_next  = code_reg;
        if (cmd.finish)
        begin
            unique case (cmd.res_kind)
                RES_HIT:
                begin
                    found_next = 1'b1;
                    fb_next    = M_OUT_W'(m_reg);
                    in_next    = N_OUT_W'(n_reg);
                    code_next  = d_ext + (d_ext >> 1);
                end
                RES_REF:
                begin
                    found_next = 1'b1;
                    fb_next    = '0;
                    in_next    = '0;
                    code_next  = '0;
                end
                default:
                begin
                    found_next = 1'b0;
                    fb_next    = '0;
                    in_next    = '0;
                    code_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg  <= target_next;
        prod_reg    <= prod_next;
        lo_base_reg <= lo_base_next;
        hi_base_reg <= hi_base_next;
        m_reg       <= m_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        found_reg   <= found_next;
        fb_reg      <= fb_next;
        in_reg      <= in_next;
        code_reg    <= code_next;
    end

    assign found            = found_reg;
    assign feedback_setting = fb_reg;
    assign input_setting    = in_reg;
    assign output_div_code  = code_reg;

endmodule

### sv/pds_ctrl.sv
// Controller of the PLL divider search: sequences the candidate loops
// and the result strobe. Uses pds_pkg.
module pds_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pds_pkg::pds_status_t status,
    output pds_pkg::pds_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import pds_pkg::*;

    pds_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.ref_eq ? ST_DONE : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (status.hit
                    || (status.m_last && status.n_last && status.d_last))
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.res_kind = RES_MISS;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_CHECK:
            begin
                cmd.finish   = status.ref_eq;
                cmd.res_kind = RES_REF;
            end
            ST_SEARCH:
            begin
                if (status.hit)
                begin
                    cmd.finish   = 1'b1;
                    cmd.res_kind = RES_HIT;
                end
                else if (!status.m_last)
                begin
                    cmd.next_m = 1'b1;
                end
                else if (!status.n_last)
                begin
                    cmd.next_n = 1'b1;
                end
                else if (!status.d_last)
                begin
                    cmd.next_d = 1'b1;
                end
                else
                begin
                    cmd.finish   = 1'b1;
                    cmd.res_kind = RES_MISS;
                end
            end
            default:
            begin
                cmd.finish = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

### sv/pll_divider_search_core.sv
// Top level of the PLL divider search: ties the controller to the datapath.
// Depends on pds_pkg, pds_ctrl, pds_datapath and the assertion macro header.
`include "pll_divider_search_core_macros.svh"

// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+------------------------------------
// request   | in        | start, busy (taken if !busy) | target_freq
// result    | out       | done (one-cycle strobe)      | found, feedback_setting,
//           |           |                              | input_setting, output_div_code
// config    | in        | cfg_valid, cfg_ready         | cfg_data (reference frequency)
//
// A request is first checked against the reference, then tries one candidate per
// cycle in the single candidate compare unit, up to OUTPUT_STEPS * INPUT_STEPS *
// FEEDBACK_STEPS candidates; no new request is taken until the search is over.
// Reset clears the controller to idle and loads the reference with 12 MHz.
// The result registers hold their values until the next result; done is high
// for exactly one cycle with them, and busy drops in the following cycle.
module pll_divider_search_core #(
    parameter int FEEDBACK_STEPS = pds_pkg::DEF_FEEDBACK_STEPS,
    parameter int INPUT_STEPS    = pds_pkg::DEF_INPUT_STEPS,
    parameter int OUTPUT_STEPS   = pds_pkg::DEF_OUTPUT_STEPS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pds_pkg::TGT_W-1:0]     target_freq,
    output logic                          done,
    output logic                          found,
    output logic [pds_pkg::M_OUT_W-1:0]   feedback_setting,
    output logic [pds_pkg::N_OUT_W-1:0]   input_setting,
    output logic [pds_pkg::CODE_W-1:0]    output_div_code,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pds_pkg::REF_W-1:0]     cfg_data
);
    import pds_pkg::*;

    pds_cmd_t    cmd;
    pds_status_t status;
    logic        accept;

    // The reference may only change between requests. A request offered in
    // the same cycle goes first, and the write waits until the search is over.
    assign cfg_ready = !busy && !start;

    // The controller walks the output step, then the input divider, then the
    // feedback divider, and stops at the first exact candidate.
    pds_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath keeps running products, so each candidate costs only adds
    // and a pair of range compares instead of a division.
    pds_datapath #(
        .FEEDBACK_STEPS (FEEDBACK_STEPS),
        .INPUT_STEPS    (INPUT_STEPS),
        .OUTPUT_STEPS   (OUTPUT_STEPS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .target_freq      (target_freq),
        .cmd              (cmd),
        .status           (status),
        .found            (found),
        .feedback_setting (feedback_setting),
        .input_setting    (input_setting),
        .output_div_code  (output_div_code)
    );

    assign accept = start && !busy;

    `PDS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
    `PDS_ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy)
    `PDS_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done && !busy)
    `PDS_ASSERT_IMPL(a_miss_zero, clk, rst_n, done && !found,
        (feedback_setting == '0) && (input_setting == '0) && (output_div_code == '0))
    `PDS_ASSERT_IMPL(a_code_legal, clk, rst_n, done, output_div_code != 2'd2)

endmodule

### sim/tb_pll_divider_search_core.sv
// Self-checking testbench for pll_divider_search_core: directed table, then random phases.
// Each result is checked against a fixed directed expectation or a local predictor of the divider search.
// Depends only on pds_pkg and the RTL of the core.
module tb_pll_divider_search_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pds_pkg::*;

    // Output divider codes as the block reports them.
    localparam bit [CODE_W-1:0] DIV_NONE    = 2'd0;
    localparam bit [CODE_W-1:0] DIV_HALF    = 2'd1;
    localparam bit [CODE_W-1:0] DIV_QUARTER = 2'd3;

    // A full miss walks 3 * 32 * 512 candidates. The watchdog allows several times
    // that walk plus the longest request gap.
    localparam int IDLE_LIMIT    = 250000;
    localparam int NUM_DIRECTED  = 23;
    localparam int NUM_PHASES    = 6;
    localparam int REQS_PER_PHASE = 14;

    typedef struct packed {
        bit               found;
        bit [M_OUT_W-1:0] fb;
        bit [N_OUT_W-1:0] in_div;
        bit [CODE_W-1:0]  code;
    } pll_setting_t;

    typedef enum bit {
        ROW_REQUEST,
        ROW_REFERENCE
    } row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        bit [31:0]    value;
        bit           fixed;
        pll_setting_t want;
    } directed_row_t;

    localparam pll_setting_t NO_MATCH  = '{1'b0, 9'd0, 5'd0, DIV_NONE};
    localparam pll_setting_t AT_REF    = '{1'b1, 9'd0, 5'd0, DIV_NONE};
    localparam pll_setting_t DONT_CARE = '{1'b0, 9'd0, 5'd0, DIV_NONE};

    // Directed part. Rows with fixed set carry an expectation that follows
    // directly from the search order; all other rows go through the predictor.
    localparam directed_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
        // Reset reference of 12 MHz.
        '{ROW_REQUEST,   32'd12000000,   1'b1, AT_REF},
        '{ROW_REQUEST,   32'd18000000,   1'b1, '{1'b1, 9'd1, 5'd0, DIV_NONE}},
        '{ROW_REQUEST,   32'd24000000,   1'b1, '{1'b1, 9'd2, 5'd0, DIV_NONE}},
        '{ROW_REQUEST,   32'd0,          1'b1, NO_MATCH},
        '{ROW_REQUEST,   32'hFFFF_FFFF,  1'b1, NO_MATCH},
        '{ROW_REQUEST,   32'd3078000000, 1'b0, DONT_CARE},  // largest feedback
        '{ROW_REQUEST,   32'd727272,     1'b0, DONT_CARE},  // largest input divider
        '{ROW_REQUEST,   32'd363636,     1'b0, DONT_CARE},  // only reachable halved
        '{ROW_REQUEST,   32'd181818,     1'b0, DONT_CARE},  // only reachable quartered
        // A zero reference makes every candidate zero.
        '{ROW_REFERENCE, 32'd0,          1'b0, DONT_CARE},
        '{ROW_REQUEST,   32'd0,          1'b1, AT_REF},
        '{ROW_REQUEST,   32'd1,          1'b1, NO_MATCH},
        // All ones in the reference register.
        '{ROW_REFERENCE, 32'd134217727,  1'b0, DONT_CARE},
        '{ROW_REQUEST,   32'd134217727,  1'b1, AT_REF},
        '{ROW_REQUEST,   32'd201326590,  1'b0, DONT_CARE},
        // Smallest legal reference.
        '{ROW_REFERENCE, 32'd1,          1'b0, DONT_CARE},
        '{ROW_REQUEST,   32'd1,          1'b1, AT_REF},
        '{ROW_REQUEST,   32'd0,          1'b0, DONT_CARE},
        '{ROW_REQUEST,   32'd256,        1'b0, DONT_CARE},
        // Largest legal reference; big products must not wrap.
        '{ROW_REFERENCE, 32'd100000000,  1'b0, DONT_CARE},
        '{ROW_REQUEST,   32'd100000000,  1'b1, AT_REF},
        '{ROW_REQUEST,   32'd150000000,  1'b0, DONT_CARE},
        '{ROW_REQUEST,   32'd3000000000, 1'b0, DONT_CARE}
    };

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [TGT_W-1:0]  target_freq;
    logic              done;
    logic              found;
    logic [M_OUT_W-1:0] feedback_setting;
    logic [N_OUT_W-1:0] input_setting;
    logic [CODE_W-1:0] output_div_code;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [REF_W-1:0]  cfg_data;

    // Our copy of the reference register, updated at each accepted write.
    bit [REF_W-1:0] reference_hz;
    pll_setting_t   pending_settings[$];
    int unsigned    mismatch_count;
    int unsigned    idle_cycles;

    pll_divider_search_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .target_freq      (target_freq),
        .done             (done),
        .found            (found),
        .feedback_setting (feedback_setting),
        .input_setting    (input_setting),
        .output_div_code  (output_div_code),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // PLL output for one candidate, kept at 64 bits so nothing wraps.
    function automatic bit [63:0] pll_freq(input bit [REF_W-1:0] refclk, input int unsigned m,
                                           input int unsigned n, input int unsigned d);
        return ((64'(refclk) * 64'(m + 2)) / 64'(n + 2)) >> d;
    endfunction

    // Walks the search in the block's order (reference check, output step, then input
    // divider, then feedback) and returns the first exact setting, or all zeros.
    function automatic pll_setting_t search_setting(input bit [REF_W-1:0] refclk,
                                                    input bit [TGT_W-1:0] tgt);
        pll_setting_t s;
        s = NO_MATCH;
        if (64'(refclk) == 64'(tgt)) begin
            s.found = 1'b1;
            return s;
        end
        for (int d = 0; d < DEF_OUTPUT_STEPS; d++) begin
            for (int n = 0; n < DEF_INPUT_STEPS; n++) begin
                for (int m = 0; m < DEF_FEEDBACK_STEPS; m++) begin
                    if (pll_freq(refclk, m, n, d) == 64'(tgt)) begin
                        s.found  = 1'b1;
                        s.fb     = M_OUT_W'(m);
                        s.in_div = N_OUT_W'(n);
                        case (d)
                            0:       s.code = DIV_NONE;
                            1:       s.code = DIV_HALF;
                            default: s.code = DIV_QUARTER;
                        endcase
                        return s;
                    end
                end
            end
        end
        return s;
    endfunction

    // Random target. Most are real PLL outputs from early in the search so the
    // run stays short; some are nudged by a few hertz and a few are pure noise,
    // which usually means a full-length miss.
    function automatic bit [TGT_W-1:0] draw_target(input bit [REF_W-1:0] refclk);
        int unsigned sel;
        int unsigned pick;
        int unsigned d;
        int unsigned n;
        int unsigned m;
        bit [63:0]   f;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return $urandom;
        pick = $urandom_range(0, 99);
        d = (pick < 85) ? 0 : (pick < 95) ? 1 : 2;
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 31);
        m = $urandom_range(0, 511);
        f = pll_freq(refclk, m, n, d);
        while (f > 64'hFFFF_FFFF && m > 0) begin
            m = m / 2;
            f = pll_freq(refclk, m, n, d);
        end
        if (sel < 15) begin
            if (f > 3 && $urandom_range(0, 1) == 1)
                f = f - $urandom_range(1, 3);
            else
                f = f + $urandom_range(1, 3);
        end
        return f[TGT_W-1:0];
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Must be called right after a rising edge. Holds start through the gap
    // low, then high until a rising edge sees busy low, which is acceptance.
    // The expectation is queued at that edge; the result still passes the check
    // state before done rises, so the checker never sees it first.
    task automatic issue_request(input bit [TGT_W-1:0] tgt, input int unsigned gap,
                                 input bit fixed, input pll_setting_t want);
        pll_setting_t s;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        target_freq <= tgt;
        do @(posedge clk); while (busy !== 1'b0);
        s = fixed ? want : search_setting(reference_hz, tgt);
        pending_settings.push_back(s);
    endtask

    // Lowers start and waits until every queued result has come and the core
    // has gone idle, then a few cycles more for busy to settle.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_settings.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called with the core idle.
    task automatic write_reference(input bit [REF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid    <= 1'b0;
        reference_hz = value;
    endtask

    // Result checker: each done strobe is compared with the oldest expectation.
    always @(posedge clk) begin : result_check
        pll_setting_t want;
        if (rst_n && done === 1'b1) begin
            if (pending_settings.size() == 0) begin
                note_mismatch("result with no request outstanding", found, 0);
            end else begin
                want = pending_settings.pop_front();
                if (found !== want.found)
                    note_mismatch("found", found, want.found);
                if (feedback_setting !== want.fb)
                    note_mismatch("feedback_setting", feedback_setting, want.fb);
                if (input_setting !== want.in_div)
                    note_mismatch("input_setting", input_setting, want.in_div);
                if (output_div_code !== want.code)
                    note_mismatch("output_div_code", output_div_code, want.code);
            end
        end
    end

    // Watchdog: any cycle that moves a request, a result or a register write
    // restarts the count.
    always @(posedge clk) begin
        if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        bit [REF_W-1:0] phase_ref [0:NUM_PHASES-1];
        bit             no_gaps;
        rst_n          = 1'b0;
        start          = 1'b0;
        target_freq    = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        idle_cycles    = 0;
        mismatch_count = 0;
        reference_hz   = REF_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table. A reference row first lets the core finish whatever
        // is in flight, since the register may only change while idle.
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (DIRECTED[i].kind == ROW_REFERENCE) begin
                wait_idle();
                write_reference(REF_W'(DIRECTED[i].value));
            end else begin
                issue_request(DIRECTED[i].value, $urandom_range(0, 16),
                              DIRECTED[i].fixed, DIRECTED[i].want);
            end
        end

        // Random phases, each under its own reference: back to the reset
        // value, both legal extremes, two legal random values and one random
        // pattern over the whole register width.
        phase_ref[0] = REF_RESET;
        phase_ref[1] = REF_W'(100000000);
        phase_ref[2] = REF_W'(1);
        phase_ref[3] = REF_W'($urandom_range(1, 100000000));
        phase_ref[4] = REF_W'($urandom_range(1, 100000000));
        phase_ref[5] = REF_W'($urandom);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_reference(phase_ref[p]);
            // Some phases send back to back, the rest with random gaps.
            no_gaps = (p == 1 || p == 4);
            for (int k = 0; k < REQS_PER_PHASE; k++) begin
                // Now and then hold off until every result is back.
                if ($urandom_range(0, 19) == 0)
                    wait_idle();
                issue_request(draw_target(reference_hz),
                              no_gaps ? 0 : $urandom_range(0, 16), 1'b0, DONT_CARE);
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
